FILE: hdl/uvs_pkg.sv
`timescale 1ns / 1ps
package uvs_pkg;

	localparam int COUNT_BITS = 13;
	localparam int DIV_BITS = COUNT_BITS + 1;
	localparam int OUT_FRAC_BITS = 15;
	localparam int POS_BITS = OUT_FRAC_BITS + 1;
	localparam int TEX_FRAC = 16;
	localparam int TEX_BITS = TEX_FRAC + 1;
	localparam int PHASE_BITS = 32;
	localparam int QUOT_BITS = PHASE_BITS + 1;
	localparam int DIV_CELLS = PHASE_BITS;
	localparam int DIV_LAT = DIV_CELLS + 2;
	localparam int HORNER_STEPS = 5;
	localparam int SINE_LAT = 3 * HORNER_STEPS + 3;
	localparam int LATENCY = DIV_LAT + SINE_LAT + 4;
	localparam int Q30_BITS = 31;

	localparam logic [Q30_BITS-1:0] Q30_ONE = 31'h4000_0000;
	localparam logic [Q30_BITS-1:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SECTOR_COUNT = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STACK_COUNT = 1'b1;

	localparam logic [COUNT_BITS-1:0] SECTOR_COUNT_RESET = COUNT_BITS'(32);
	localparam logic [COUNT_BITS-1:0] STACK_COUNT_RESET = COUNT_BITS'(16);

	typedef struct packed {
		logic [COUNT_BITS-1:0] stack_index;
		logic [COUNT_BITS-1:0] sector_index;
	} request_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] pos_x;
		logic signed [POS_BITS-1:0] pos_y;
		logic signed [POS_BITS-1:0] pos_z;
		logic [TEX_BITS-1:0] tex_s;
		logic [TEX_BITS-1:0] tex_t;
		logic index_error;
	} result_t;

	// One slot of the long-division chain.
	typedef struct packed {
		logic [DIV_BITS-1:0] rem;
		logic [QUOT_BITS-1:0] quot;
		logic [TEX_BITS-1:0] tex;
	} div_lane_t;

	// One slot of the Horner chain of the quarter-wave sine.
	typedef struct packed {
		logic [Q30_BITS-1:0] x;
		logic [31:0] x2;
		logic [Q30_BITS-1:0] t;
	} horner_lane_t;

	function automatic int horner_div(input int step);
		case (step)
			0: return 110;
			1: return 72;
			2: return 42;
			3: return 20;
			default: return 6;
		endcase
	endfunction

endpackage

FILE: hdl/uvs_div_cell.sv
`timescale 1ns / 1ps
module uvs_div_cell (
	input logic clk,
	input logic [uvs_pkg::DIV_BITS-1:0] divisor,
	input logic capture,
	input uvs_pkg::div_lane_t lane_in,
	output uvs_pkg::div_lane_t lane_out
);

	logic [uvs_pkg::DIV_BITS:0] dbl;
	logic [uvs_pkg::DIV_BITS:0] diff;
	logic [uvs_pkg::DIV_BITS:0] rsum;
	logic bit_q;
	logic round_up;
	logic [uvs_pkg::QUOT_BITS-1:0] tex_sum;
	uvs_pkg::div_lane_t lane_s1;

	always_comb begin
		dbl = {lane_in.rem, 1'b0};
		diff = dbl - {1'b0, divisor};
		bit_q = dbl >= {1'b0, divisor};
		// Rounded quotient so far: add half the divisor to the remainder.
		rsum = {1'b0, lane_in.rem} + {2'b00, divisor[uvs_pkg::DIV_BITS-1:1]};
		round_up = rsum >= {1'b0, divisor};
		tex_sum = lane_in.quot + uvs_pkg::QUOT_BITS'(round_up);
	end

	always_ff @(posedge clk) begin
		lane_s1.rem <= bit_q ? diff[uvs_pkg::DIV_BITS-1:0] : dbl[uvs_pkg::DIV_BITS-1:0];
		lane_s1.quot <= {lane_in.quot[uvs_pkg::QUOT_BITS-2:0], bit_q};
		lane_s1.tex <= capture ? tex_sum[uvs_pkg::TEX_BITS-1:0] : lane_in.tex;
	end

	assign lane_out = lane_s1;

endmodule

FILE: hdl/uvs_div_chain.sv
`timescale 1ns / 1ps
module uvs_div_chain #(
	parameter int TEX_TAP = uvs_pkg::TEX_FRAC
) (
	input logic clk,
	input logic [uvs_pkg::DIV_BITS-1:0] divisor,
	input logic [uvs_pkg::COUNT_BITS-1:0] numer,
	output logic [uvs_pkg::PHASE_BITS-1:0] phase,
	output logic [uvs_pkg::TEX_BITS-1:0] tex
);

	uvs_pkg::div_lane_t lane [uvs_pkg::DIV_CELLS+1];
	uvs_pkg::div_lane_t head_s1;
	logic [uvs_pkg::DIV_BITS-1:0] numer_ext;
	logic ge;
	logic [uvs_pkg::DIV_BITS:0] rsum;
	logic round_up;
	logic [uvs_pkg::QUOT_BITS-1:0] qsum;
	logic [uvs_pkg::PHASE_BITS-1:0] phase_s34;
	logic [uvs_pkg::TEX_BITS-1:0] tex_s34;

	assign numer_ext = {1'b0, numer};
	assign ge = numer_ext >= divisor;

	// Integer bit of the quotient; every cell after it adds one fraction bit.
	always_ff @(posedge clk) begin
		head_s1.rem <= ge ? numer_ext - divisor : numer_ext;
		head_s1.quot <= uvs_pkg::QUOT_BITS'(ge);
		head_s1.tex <= '0;
	end

	assign lane[0] = head_s1;

	for (genvar k = 0; k < uvs_pkg::DIV_CELLS; k++) begin : g_cell
		uvs_div_cell u_cell (
			.clk(clk),
			.divisor(divisor),
			.capture(k == TEX_TAP),
			.lane_in(lane[k]),
			.lane_out(lane[k+1])
		);
	end

	always_comb begin
		rsum = {1'b0, lane[uvs_pkg::DIV_CELLS].rem} + {2'b00, divisor[uvs_pkg::DIV_BITS-1:1]};
		round_up = rsum >= {1'b0, divisor};
		qsum = lane[uvs_pkg::DIV_CELLS].quot + uvs_pkg::QUOT_BITS'(round_up);
	end

	always_ff @(posedge clk) begin
		phase_s34 <= qsum[uvs_pkg::PHASE_BITS-1:0];
		tex_s34 <= lane[uvs_pkg::DIV_CELLS].tex;
	end

	assign phase = phase_s34;
	assign tex = tex_s34;

endmodule

FILE: hdl/uvs_horner_cell.sv
`timescale 1ns / 1ps
module uvs_horner_cell #(
	parameter int DIVISOR = 6
) (
	input logic clk,
	input uvs_pkg::horner_lane_t lane_in,
	output uvs_pkg::horner_lane_t lane_out
);

	// Truncated reciprocal; the estimate is low by at most one.
	localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / DIVISOR;
	localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
	localparam logic [31:0] DIV_Q = 32'(DIVISOR);

	logic [62:0] prod_s1;
	logic [30:0] x_s1;
	logic [31:0] x2_s1;
	logic [31:0] p;
	logic [63:0] pm_s2;
	logic [31:0] p_s2;
	logic [30:0] x_s2;
	logic [31:0] x2_s2;
	logic [31:0] q;
	logic [31:0] qd;
	logic [31:0] rem;
	logic [31:0] qc;
	uvs_pkg::horner_lane_t lane_s3;

	always_ff @(posedge clk) begin
		prod_s1 <= lane_in.x2 * lane_in.t;
		x_s1 <= lane_in.x;
		x2_s1 <= lane_in.x2;
	end

	assign p = prod_s1[61:30];

	always_ff @(posedge clk) begin
		pm_s2 <= p * RECIP;
		p_s2 <= p;
		x_s2 <= x_s1;
		x2_s2 <= x2_s1;
	end

	always_comb begin
		q = pm_s2[63:32];
		qd = q * DIV_Q;
		rem = p_s2 - qd;
		qc = q + 32'(rem >= DIV_Q);
	end

	always_ff @(posedge clk) begin
		lane_s3.t <= uvs_pkg::Q30_ONE - qc[30:0];
		lane_s3.x <= x_s2;
		lane_s3.x2 <= x2_s2;
	end

	assign lane_out = lane_s3;

endmodule

FILE: hdl/uvs_quarter_sine.sv
`timescale 1ns / 1ps
module uvs_quarter_sine (
	input logic clk,
	input logic [uvs_pkg::Q30_BITS-1:0] angle,
	output logic [uvs_pkg::Q30_BITS-1:0] sine
);

	logic [61:0] xp_s1;
	logic [61:0] x2p_s2;
	logic [30:0] x_s2;
	logic [61:0] sp_s18;
	uvs_pkg::horner_lane_t lane [uvs_pkg::HORNER_STEPS+1];

	// Quarter turns to radians in Q30.
	always_ff @(posedge clk) begin
		xp_s1 <= angle * uvs_pkg::HALF_PI_Q30;
	end

	always_ff @(posedge clk) begin
		x2p_s2 <= xp_s1[60:30] * xp_s1[60:30];
		x_s2 <= xp_s1[60:30];
	end

	assign lane[0] = '{x: x_s2, x2: x2p_s2[61:30], t: uvs_pkg::Q30_ONE};

	for (genvar k = 0; k < uvs_pkg::HORNER_STEPS; k++) begin : g_step
		uvs_horner_cell #(
			.DIVISOR(uvs_pkg::horner_div(k))
		) u_step (
			.clk(clk),
			.lane_in(lane[k]),
			.lane_out(lane[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sp_s18 <= lane[uvs_pkg::HORNER_STEPS].x * lane[uvs_pkg::HORNER_STEPS].t;
	end

	assign sine = sp_s18[60:30];

endmodule

FILE: hdl/uv_sphere_vertex_generator_core.sv
`timescale 1ns / 1ps
// Throughput: one vertex per cycle; busy stays low, as the 32-cell long-division
// chains and the four Horner sine pipelines are fully pipelined and stall-free.
// Results leave on done for one cycle each, in request order; the receiver cannot stall.
// Reset (arst_n low) clears all valid flags and sets sector_count to 32, stack_count to 16.
module uv_sphere_vertex_generator_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input uvs_pkg::request_t request,
	output logic done,
	output uvs_pkg::result_t result,
	input logic cfg_we,
	input logic [uvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [uvs_pkg::COUNT_BITS-1:0] cfg_data
);

	localparam int SHIFT = 60 - uvs_pkg::OUT_FRAC_BITS;
	localparam logic [63:0] OUT_MAX = (64'd1 << uvs_pkg::OUT_FRAC_BITS) - 64'd1;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [uvs_pkg::TEX_BITS-1:0] TEX_ONE = uvs_pkg::TEX_BITS'(65536);
	localparam logic [uvs_pkg::POS_BITS-1:0] POS_MIN = {1'b1, {uvs_pkg::OUT_FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic valid;
		logic err;
		logic [1:0] sec_quad;
		logic [1:0] stk_quad;
		logic [uvs_pkg::TEX_BITS-1:0] tex_s;
		logic [uvs_pkg::TEX_BITS-1:0] tex_t;
	} side_t;

	function automatic logic [uvs_pkg::POS_BITS-1:0] round_q60(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] rnd;
		logic [63:0] rnd_neg;
		mag = v[63] ? 64'(-v) : 64'(v);
		rnd = (mag + (64'd1 << (SHIFT - 1))) >> SHIFT;
		if (rnd > OUT_MAX) begin
			rnd = OUT_MAX;
		end
		rnd_neg = -rnd;
		return v[63] ? rnd_neg[uvs_pkg::POS_BITS-1:0] : rnd[uvs_pkg::POS_BITS-1:0];
	endfunction

	logic [uvs_pkg::COUNT_BITS-1:0] sector_count_q;
	logic [uvs_pkg::COUNT_BITS-1:0] stack_count_q;
	logic [uvs_pkg::COUNT_BITS-1:0] ns;
	logic [uvs_pkg::COUNT_BITS-1:0] nt;
	logic [uvs_pkg::DIV_BITS-1:0] sec_div;
	logic [uvs_pkg::DIV_BITS-1:0] stk_div;
	logic accept;
	logic range_ok;

	logic valid_s1;
	logic err_s1;
	logic [uvs_pkg::COUNT_BITS-1:0] stack_idx_s1;
	logic [uvs_pkg::COUNT_BITS-1:0] sector_idx_s1;
	logic valid_pipe_q [uvs_pkg::DIV_LAT];
	logic err_pipe_q [uvs_pkg::DIV_LAT];

	logic [uvs_pkg::PHASE_BITS-1:0] sec_quot;
	logic [uvs_pkg::PHASE_BITS-1:0] stk_quot;
	logic [uvs_pkg::PHASE_BITS-1:0] sec_phase;
	logic [uvs_pkg::PHASE_BITS-1:0] stk_phase;
	logic [uvs_pkg::TEX_BITS-1:0] tex_s_div;
	logic [uvs_pkg::TEX_BITS-1:0] tex_t_div;

	logic [uvs_pkg::Q30_BITS-1:0] sec_a_s36;
	logic [uvs_pkg::Q30_BITS-1:0] sec_b_s36;
	logic [uvs_pkg::Q30_BITS-1:0] stk_a_s36;
	logic [uvs_pkg::Q30_BITS-1:0] stk_b_s36;
	side_t side_s36;
	side_t back_q [uvs_pkg::SINE_LAT];

	logic [uvs_pkg::Q30_BITS-1:0] sec_a_sin;
	logic [uvs_pkg::Q30_BITS-1:0] sec_b_sin;
	logic [uvs_pkg::Q30_BITS-1:0] stk_a_sin;
	logic [uvs_pkg::Q30_BITS-1:0] stk_b_sin;
	logic signed [31:0] ssin;
	logic signed [31:0] scos;
	logic signed [31:0] tsin;
	logic signed [31:0] tcos;

	logic signed [63:0] x_s55;
	logic signed [63:0] y_s55;
	logic signed [63:0] z_s55;
	side_t side_s55;

	logic done_s56;
	uvs_pkg::result_t result_s56;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= uvs_pkg::SECTOR_COUNT_RESET;
			stack_count_q <= uvs_pkg::STACK_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				uvs_pkg::CFG_SECTOR_COUNT: sector_count_q <= cfg_data;
				uvs_pkg::CFG_STACK_COUNT: stack_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero count acts as one. The stack divides by twice its count, so that
	// the half-turn phase and its rounding come out of the same chain.
	assign ns = (sector_count_q == '0) ? uvs_pkg::COUNT_BITS'(1) : sector_count_q;
	assign nt = (stack_count_q == '0) ? uvs_pkg::COUNT_BITS'(1) : stack_count_q;
	assign sec_div = {1'b0, ns};
	assign stk_div = {nt, 1'b0};
	assign range_ok = (request.stack_index <= nt) && (request.sector_index <= ns);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= !range_ok;
		stack_idx_s1 <= request.stack_index;
		sector_idx_s1 <= request.sector_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < uvs_pkg::DIV_LAT; k++) begin
				valid_pipe_q[k] <= 1'b0;
			end
		end else begin
			valid_pipe_q[0] <= valid_s1;
			for (int k = 1; k < uvs_pkg::DIV_LAT; k++) begin
				valid_pipe_q[k] <= valid_pipe_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		err_pipe_q[0] <= err_s1;
		for (int k = 1; k < uvs_pkg::DIV_LAT; k++) begin
			err_pipe_q[k] <= err_pipe_q[k-1];
		end
	end

	uvs_div_chain #(
		.TEX_TAP(uvs_pkg::TEX_FRAC)
	) u_sec_div (
		.clk(clk),
		.divisor(sec_div),
		.numer(sector_idx_s1),
		.phase(sec_quot),
		.tex(tex_s_div)
	);

	uvs_div_chain #(
		.TEX_TAP(uvs_pkg::TEX_FRAC + 1)
	) u_stk_div (
		.clk(clk),
		.divisor(stk_div),
		.numer(stack_idx_s1),
		.phase(stk_quot),
		.tex(tex_t_div)
	);

	// The stack angle starts at the north pole, a quarter turn up.
	assign sec_phase = sec_quot;
	assign stk_phase = QUARTER_TURN - stk_quot;

	always_ff @(posedge clk) begin
		sec_a_s36 <= {1'b0, sec_phase[29:0]};
		sec_b_s36 <= uvs_pkg::Q30_ONE - {1'b0, sec_phase[29:0]};
		stk_a_s36 <= {1'b0, stk_phase[29:0]};
		stk_b_s36 <= uvs_pkg::Q30_ONE - {1'b0, stk_phase[29:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s36 <= '0;
		end else begin
			side_s36.valid <= valid_pipe_q[uvs_pkg::DIV_LAT-1];
			side_s36.err <= err_pipe_q[uvs_pkg::DIV_LAT-1];
			side_s36.sec_quad <= sec_phase[31:30];
			side_s36.stk_quad <= stk_phase[31:30];
			side_s36.tex_s <= tex_s_div;
			side_s36.tex_t <= tex_t_div;
		end
	end

	uvs_quarter_sine u_sec_a (.clk(clk), .angle(sec_a_s36), .sine(sec_a_sin));
	uvs_quarter_sine u_sec_b (.clk(clk), .angle(sec_b_s36), .sine(sec_b_sin));
	uvs_quarter_sine u_stk_a (.clk(clk), .angle(stk_a_s36), .sine(stk_a_sin));
	uvs_quarter_sine u_stk_b (.clk(clk), .angle(stk_b_s36), .sine(stk_b_sin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < uvs_pkg::SINE_LAT; k++) begin
				back_q[k] <= '0;
			end
		end else begin
			back_q[0] <= side_s36;
			for (int k = 1; k < uvs_pkg::SINE_LAT; k++) begin
				back_q[k] <= back_q[k-1];
			end
		end
	end

	always_comb begin
		case (back_q[uvs_pkg::SINE_LAT-1].sec_quad)
			2'd0: begin
				ssin = signed'({1'b0, sec_a_sin});
				scos = signed'({1'b0, sec_b_sin});
			end
			2'd1: begin
				ssin = signed'({1'b0, sec_b_sin});
				scos = -signed'({1'b0, sec_a_sin});
			end
			2'd2: begin
				ssin = -signed'({1'b0, sec_a_sin});
				scos = -signed'({1'b0, sec_b_sin});
			end
			default: begin
				ssin = -signed'({1'b0, sec_b_sin});
				scos = signed'({1'b0, sec_a_sin});
			end
		endcase
		case (back_q[uvs_pkg::SINE_LAT-1].stk_quad)
			2'd0: begin
				tsin = signed'({1'b0, stk_a_sin});
				tcos = signed'({1'b0, stk_b_sin});
			end
			2'd1: begin
				tsin = signed'({1'b0, stk_b_sin});
				tcos = -signed'({1'b0, stk_a_sin});
			end
			2'd2: begin
				tsin = -signed'({1'b0, stk_a_sin});
				tcos = -signed'({1'b0, stk_b_sin});
			end
			default: begin
				tsin = -signed'({1'b0, stk_b_sin});
				tcos = signed'({1'b0, stk_a_sin});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		x_s55 <= tcos * scos;
		y_s55 <= tcos * ssin;
		z_s55 <= {{2{tsin[31]}}, tsin, 30'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s55 <= '0;
		end else begin
			side_s55 <= back_q[uvs_pkg::SINE_LAT-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s56 <= 1'b0;
		end else begin
			done_s56 <= side_s55.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (side_s55.err) begin
			result_s56.pos_x <= '0;
			result_s56.pos_y <= '0;
			result_s56.pos_z <= '0;
			result_s56.tex_s <= '0;
			result_s56.tex_t <= '0;
			result_s56.index_error <= 1'b1;
		end else begin
			result_s56.pos_x <= round_q60(x_s55);
			result_s56.pos_y <= round_q60(y_s55);
			result_s56.pos_z <= round_q60(z_s55);
			result_s56.tex_s <= side_s55.tex_s;
			result_s56.tex_t <= side_s55.tex_t;
			result_s56.index_error <= 1'b0;
		end
	end

	assign done = done_s56;
	assign result = result_s56;

`ifndef SYNTHESIS
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, uvs_pkg::LATENCY))
		else $error("done without a matching accepted request");

	a_in_range_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && range_ok) |-> ##(uvs_pkg::LATENCY) (done && !result.index_error))
		else $error("in-range request did not complete cleanly");

	a_output_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.index_error) |-> (result.tex_s <= TEX_ONE && result.tex_t <= TEX_ONE
			&& result.pos_x != POS_MIN && result.pos_y != POS_MIN && result.pos_z != POS_MIN))
		else $error("result outside saturation or texture range");
`endif

endmodule
